>>> hw/rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue core.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // Default number of cells, data width of one stored item
  localparam int unsigned DequeDepth = 64;
  localparam int unsigned DataW      = 32;

  // Input opcodes
  typedef enum logic [2:0] {
    OpPushFront = 3'd0,
    OpPushBack  = 3'd1,
    OpPopFront  = 3'd2,
    OpPopBack   = 3'd3,
    OpList      = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatEmpty = 2'd1,
    StatFull  = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CmdHold     = 3'd0,
    CmdShiftIn  = 3'd1,  // push front: every cell takes its left neighbor
    CmdShiftOut = 3'd2,  // pop front: every cell takes its right neighbor
    CmdAppend   = 3'd3,  // push back: the cell at the fill position loads
    CmdRotate   = 3'd4   // list: occupied cells rotate one place toward the head
  } cell_cmd_e;

  // Control bundle from the sequencer to the cells
  typedef struct packed {
    cell_cmd_e         cmd;
    logic signed [DataW-1:0] value;
  } cell_ctrl_t;

  // Input item
  typedef struct packed {
    logic [2:0]              opcode;
    logic signed [DataW-1:0] push_value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [1:0]              status;
    logic                    last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/deq_cell.sv
// One storage cell of the deque chain.
`timescale 1ns / 1ps
`default_nettype none

module deq_cell #(
  parameter int unsigned CntW    = 7,
  parameter int unsigned CellIdx = 0
) (
  input  wire logic                                   clk_i,
  input  wire deq_pkg::cell_ctrl_t                    ctrl_i,
  input  wire logic [CntW-1:0]                        count_i,
  input  wire logic signed [deq_pkg::DataW-1:0]       left_i,
  input  wire logic signed [deq_pkg::DataW-1:0]       right_i,
  input  wire logic signed [deq_pkg::DataW-1:0]       head_i,
  output logic signed [deq_pkg::DataW-1:0]            data_o
);

  logic signed [deq_pkg::DataW-1:0] data_q, data_d;
  logic is_fill_pos;  // first free slot
  logic is_tail;      // last occupied slot

  assign is_fill_pos = (count_i == CntW'(CellIdx));
  assign is_tail     = (count_i == CntW'(CellIdx + 1));

  // Next value depends on the broadcast command and the cell position
  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.cmd)
      deq_pkg::CmdShiftIn:  data_d = left_i;
      deq_pkg::CmdShiftOut: data_d = right_i;
      deq_pkg::CmdAppend: begin
        if (is_fill_pos) data_d = ctrl_i.value;
      end
      deq_pkg::CmdRotate: begin
        if (is_tail) begin
          data_d = head_i;
        end else if (count_i > CntW'(CellIdx)) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> hw/rtl/double_ended_queue_core.sv
// Top level of the double-ended queue: sequencer, output register and cell chain.
//
// Usage:
//  - Input channel in_valid_i / in_ready_o / in_item_i carries an opcode and a
//    value; output channel out_valid_o / out_ready_i / out_item_o carries results.
//  - Items live in a chain of DEPTH cells; the front item sits in cell 0.
//    Push front shifts the chain right, pop front shifts it left, push back
//    loads the first free cell, pop back just shrinks the fill count.
//  - Push and pop: one result, registered in the cycle after acceptance. The next
//    item is taken in the following cycle, so these run at one item per cycle
//    as long as the output is drained.
//  - List of N items: while the output is drained, the occupied cells rotate toward
//    cell 0 once per cycle and cell 0 is copied out each cycle, one result per
//    cell; the first result is registered once the sequencer is in the list
//    state. The input is held off during the rotation; the chain ends unchanged.
//  - A list of an empty deque gives a single empty status.
//  - A stall on the output freezes the rotation; the pending result stays.
//  - Reset empties the deque at once; stored data is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core #(
  parameter int unsigned DEPTH = deq_pkg::DequeDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire deq_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output deq_pkg::out_item_t       out_item_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StList = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       list_cnt_q, list_cnt_d;
  logic                  out_valid_q, out_valid_d;
  deq_pkg::out_item_t    out_q, out_d;
  deq_pkg::cell_ctrl_t   ctrl;

  logic signed [deq_pkg::DataW-1:0] cell_data [DEPTH];

  logic in_fire, out_free, is_full, is_empty, list_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CntW'(DEPTH));
  assign is_empty   = (count_q == '0);
  assign list_last  = (list_cnt_q == count_q - CntW'(1));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    list_cnt_d  = list_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctrl.cmd    = deq_pkg::CmdHold;
    ctrl.value  = in_item_i.push_value;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          out_d.read_value  = '0;
          out_d.status      = deq_pkg::StatOk;
          out_d.last_of_run = 1'b1;
          unique case (in_item_i.opcode)
            deq_pkg::OpPushFront, deq_pkg::OpPushBack: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                out_d.status = deq_pkg::StatFull;
              end else begin
                ctrl.cmd = (in_item_i.opcode == deq_pkg::OpPushFront) ?
                           deq_pkg::CmdShiftIn : deq_pkg::CmdAppend;
                count_d  = count_q + CntW'(1);
              end
            end
            deq_pkg::OpPopFront, deq_pkg::OpPopBack: begin
              out_valid_d = 1'b1;
              if (is_empty) begin
                out_d.status = deq_pkg::StatEmpty;
              end else begin
                if (in_item_i.opcode == deq_pkg::OpPopFront) begin
                  ctrl.cmd = deq_pkg::CmdShiftOut;
                end
                count_d = count_q - CntW'(1);
              end
            end
            deq_pkg::OpList: begin
              if (is_empty) begin
                out_valid_d  = 1'b1;
                out_d.status = deq_pkg::StatEmpty;
              end else begin
                list_cnt_d = '0;
                state_d    = StList;
              end
            end
            default: ;  // unused opcode: no result
          endcase
        end
      end
      StList: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.read_value  = cell_data[0];
          out_d.status      = deq_pkg::StatOk;
          out_d.last_of_run = list_last;
          ctrl.cmd          = deq_pkg::CmdRotate;
          list_cnt_d        = list_cnt_q + CntW'(1);
          if (list_last) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      list_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      list_cnt_q  <= list_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [deq_pkg::DataW-1:0] left_data, right_data;

    if (i == 0) begin : g_head
      assign left_data = in_item_i.push_value;
    end else begin : g_body
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_data = cell_data[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end

    deq_cell #(
      .CntW    (CntW),
      .CellIdx (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .left_i  (left_data),
      .right_i (right_data),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count above depth");

  a_list_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StList) |=> (count_q == $past(count_q)))
    else $error("fill count changed during list");

  a_list_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StList) |-> (list_cnt_q < count_q))
    else $error("list cursor out of range");

  a_no_input_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StList) |-> !in_ready_o)
    else $error("input taken during list");

endmodule

`default_nettype wire
